/* src/impq_pkg.sv */
// ----------------------------------------------------------------------------
// impq_pkg: shared types and constants of the indexed minimum priority queue
// Beat layouts, status codes and the cell control group.
// ----------------------------------------------------------------------------
package impq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int WEIGHT_BITS_DEF = 32;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_KEPT     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_POPPED   = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [15:0] node_key;
        logic [31:0] path_weight;
        logic [31:0] edge_length;
        logic [15:0] prev_node;
        logic [15:0] via_edge;
    } req_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_node;
        logic [31:0] out_weight;
        logic [31:0] out_length;
        logic [15:0] out_prev;
        logic [15:0] out_edge;
    } rsp_beat_t;

    // per-cell control
    typedef struct packed {
        logic load;       // take a fresh entry
        logic take_next;  // take the neighbour's entry
        logic update;     // replace weight, predecessor and edge
    } cell_ctrl_t;

endpackage

/* src/impq_if.sv */
// ----------------------------------------------------------------------------
// impq_if: valid/ready channel
// Carries one beat of type T from source to sink.
// ----------------------------------------------------------------------------
interface impq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/impq_cell.sv */
// ----------------------------------------------------------------------------
// impq_cell: one queue slot
// Holds one entry; loads a fresh one, takes its neighbour's or updates it.
// ----------------------------------------------------------------------------
module impq_cell #(
    parameter int WEIGHT_BITS = impq_pkg::WEIGHT_BITS_DEF
) (
    input  logic                   clk,
    input  impq_pkg::cell_ctrl_t   ctrl,
    input  logic [15:0]            new_key,
    input  logic [WEIGHT_BITS-1:0] new_weight,
    input  logic [31:0]            new_length,
    input  logic [15:0]            new_prev,
    input  logic [15:0]            new_via,
    input  logic [15:0]            nxt_key,
    input  logic [WEIGHT_BITS-1:0] nxt_weight,
    input  logic [31:0]            nxt_length,
    input  logic [15:0]            nxt_prev,
    input  logic [15:0]            nxt_via,
    output logic [15:0]            key,
    output logic [WEIGHT_BITS-1:0] weight,
    output logic [31:0]            length,
    output logic [15:0]            prev,
    output logic [15:0]            via
);
    import impq_pkg::*;

    logic [15:0]            key_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [31:0]            length_reg;
    logic [15:0]            prev_reg;
    logic [15:0]            via_reg;

    // load, shift from neighbour or update in place
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_reg    <= new_key;
            weight_reg <= new_weight;
            length_reg <= new_length;
            prev_reg   <= new_prev;
            via_reg    <= new_via;
        end
        else if (ctrl.take_next)
        begin
            key_reg    <= nxt_key;
            weight_reg <= nxt_weight;
            length_reg <= nxt_length;
            prev_reg   <= nxt_prev;
            via_reg    <= nxt_via;
        end
        else if (ctrl.update)
        begin
            weight_reg <= new_weight;
            prev_reg   <= new_prev;
            via_reg    <= new_via;
        end
    end

    assign key    = key_reg;
    assign weight = weight_reg;
    assign length = length_reg;
    assign prev   = prev_reg;
    assign via    = via_reg;

endmodule

/* src/indexed_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// indexed_min_priority_queue: keyed minimum queue with decrease-key
// A row of slot cells in arrival order, with a scan head at cell zero.
// ----------------------------------------------------------------------------
// Usage:
//   req carries push (decrease-key) and pop beats, rsp carries one result
//   beat per request; both are valid/ready channels.
//   A push compares its key against every cell at once; its result is
//   registered and shows the cycle after acceptance.
//   A pop rotates the whole cell row once round so that every slot passes
//   the head comparator, then closes the gap. A pop of an empty queue
//   answers like a push.
//   The full-row rotation sets the pop time; pushes sustain one beat per
//   cycle while the receiver keeps up and no pop is in progress.
//   Reset empties the queue at once; no clearing pass is needed.
//   While rsp is stalled the held result stays put and req takes no beat.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue #(
    parameter int QUEUE_DEPTH = impq_pkg::QUEUE_DEPTH_DEF,
    parameter int WEIGHT_BITS = impq_pkg::WEIGHT_BITS_DEF
) (
    input logic  clk,
    input logic  rst_n,
    impq_if.sink req,
    impq_if.source rsp
);
    import impq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_REMOVE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [SW-1:0] best_idx_reg, best_idx_next;
    logic [WEIGHT_BITS-1:0] best_w_reg, best_w_next;
    logic [15:0] best_key_reg, best_key_next;
    logic [31:0] best_len_reg, best_len_next;
    logic [15:0] best_prev_reg, best_prev_next;
    logic [15:0] best_via_reg, best_via_next;
    logic out_valid_reg, out_valid_next;
    rsp_beat_t out_beat_reg, out_beat_next;

    logic [15:0]            c_key    [QUEUE_DEPTH];
    logic [WEIGHT_BITS-1:0] c_weight [QUEUE_DEPTH];
    logic [31:0]            c_length [QUEUE_DEPTH];
    logic [15:0]            c_prev   [QUEUE_DEPTH];
    logic [15:0]            c_via    [QUEUE_DEPTH];
    cell_ctrl_t             c_ctrl   [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] hit;
    logic [QUEUE_DEPTH-1:0] first_hit;
    logic [WEIGHT_BITS-1:0] hit_weight;
    logic                   found;
    logic [WEIGHT_BITS-1:0] in_w;
    logic                   accept;
    logic                   out_free;
    logic                   do_push;
    logic                   do_update;
    logic                   do_insert;
    logic                   head_ok;
    logic [63:0]            best_w_wide;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign in_w      = WEIGHT_BITS'(req.payload.path_weight);

    // match the key against every occupied cell, keep the first hit
    always_comb
    begin
        logic seen;
        seen       = 1'b0;
        hit_weight = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit[i]       = (CW'(i) < count_reg) && (c_key[i] == req.payload.node_key);
            first_hit[i] = hit[i] && !seen;
            seen         = seen || hit[i];
            hit_weight   = hit_weight | (c_weight[i] & {WEIGHT_BITS{first_hit[i]}});
        end
        found = seen;
    end

    assign do_push   = accept && (req.payload.req_type == REQ_PUSH);
    assign do_update = do_push && found && (hit_weight > in_w);
    assign do_insert = do_push && !found && (count_reg != CW'(QUEUE_DEPTH));

    // cell control: load at the tail, update a heavier hit, rotate or close the gap
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            c_ctrl[i].load      = do_insert && (count_reg == CW'(i));
            c_ctrl[i].update    = do_update && first_hit[i];
            c_ctrl[i].take_next = (state_reg == S_SCAN)
                                  || ((state_reg == S_REMOVE) && (SW'(i) >= best_idx_reg));
        end
    end

    // cell row
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        localparam int NX = (g + 1) % QUEUE_DEPTH;
        impq_cell #(.WEIGHT_BITS(WEIGHT_BITS)) u_cell (
            .clk        (clk),
            .ctrl       (c_ctrl[g]),
            .new_key    (req.payload.node_key),
            .new_weight (in_w),
            .new_length (req.payload.edge_length),
            .new_prev   (req.payload.prev_node),
            .new_via    (req.payload.via_edge),
            .nxt_key    (c_key[NX]),
            .nxt_weight (c_weight[NX]),
            .nxt_length (c_length[NX]),
            .nxt_prev   (c_prev[NX]),
            .nxt_via    (c_via[NX]),
            .key        (c_key[g]),
            .weight     (c_weight[g]),
            .length     (c_length[g]),
            .prev       (c_prev[g]),
            .via        (c_via[g])
        );
    end

    assign head_ok     = (CW'(scan_reg) < count_reg)
                         && ((scan_reg == '0) || (c_weight[0] < best_w_reg));
    assign best_w_wide = 64'(best_w_reg);

    // sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        best_idx_next  = best_idx_reg;
        best_w_next    = best_w_reg;
        best_key_next  = best_key_reg;
        best_len_next  = best_len_reg;
        best_prev_next = best_prev_reg;
        best_via_next  = best_via_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_beat_next  = out_beat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_beat_next  = '0;
                    if (req.payload.req_type == REQ_PUSH)
                    begin
                        if (found)
                            out_beat_next.status = do_update ? ST_UPDATED : ST_KEPT;
                        else if (do_insert)
                        begin
                            out_beat_next.status = ST_INSERTED;
                            count_next           = count_reg + 1'b1;
                        end
                        else
                            out_beat_next.status = ST_FULL;
                    end
                    else if (count_reg == '0)
                        out_beat_next.status = ST_EMPTY;
                    else
                    begin
                        out_valid_next = 1'b0;
                        scan_next      = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // capture a strictly smaller weight; oldest wins ties
                if (head_ok)
                begin
                    best_idx_next  = scan_reg;
                    best_w_next    = c_weight[0];
                    best_key_next  = c_key[0];
                    best_len_next  = c_length[0];
                    best_prev_next = c_prev[0];
                    best_via_next  = c_via[0];
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SW'(QUEUE_DEPTH - 1))
                    state_next = S_REMOVE;
            end
            S_REMOVE:
            begin
                out_valid_next           = 1'b1;
                out_beat_next.status     = ST_POPPED;
                out_beat_next.out_node   = best_key_reg;
                out_beat_next.out_weight = best_w_wide[31:0];
                out_beat_next.out_length = best_len_reg;
                out_beat_next.out_prev   = best_prev_reg;
                out_beat_next.out_edge   = best_via_reg;
                count_next               = count_reg - 1'b1;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_w_reg    <= best_w_next;
        best_key_reg  <= best_key_next;
        best_len_reg  <= best_len_next;
        best_prev_reg <= best_prev_next;
        best_via_reg  <= best_via_next;
        out_beat_reg  <= out_beat_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_beat_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("scan started on an empty queue");

    a_remove_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |=> (rsp.valid && rsp.payload.status == ST_POPPED))
        else $error("pop did not present its result");

    a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
        !(do_update && do_insert))
        else $error("push both updated and inserted");
`endif

endmodule

/* dv/tb_indexed_min_priority_queue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_min_priority_queue: checks the keyed minimum queue
// Drives push and pop beats, predicts each result with a local model of the
// slot row, and compares every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_indexed_min_priority_queue;
    import impq_pkg::*;

    localparam int DEPTH     = QUEUE_DEPTH_DEF;
    localparam int CYC_LIMIT = 400000;

    logic clk;
    logic rst_n;

    impq_if #(.T(req_beat_t)) req ();
    impq_if #(.T(rsp_beat_t)) rsp ();

    indexed_min_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor state: slots in arrival order
    logic [15:0] q_key[$];
    logic [31:0] q_wgt[$];
    logic [31:0] q_len[$];
    logic [15:0] q_prv[$];
    logic [15:0] q_edg[$];

    rsp_beat_t expected_rsp[$];
    int        fail_count;
    int        cyc;
    bit        hold_off;
    bit        stall_en;

    // Work out the result of one accepted request and update the slot row
    function automatic rsp_beat_t queue_predict(req_beat_t b);
        rsp_beat_t r;
        int        at;
        int        best;
        r  = '0;
        at = -1;
        if (b.req_type == REQ_PUSH) begin
            for (int i = 0; i < q_key.size(); i++)
                if (at < 0 && q_key[i] == b.node_key)
                    at = i;
            if (at >= 0) begin
                if (q_wgt[at] > b.path_weight) begin
                    q_wgt[at] = b.path_weight;
                    q_prv[at] = b.prev_node;
                    q_edg[at] = b.via_edge;
                    r.status  = ST_UPDATED;
                end
                else
                    r.status = ST_KEPT;
            end
            else if (q_key.size() >= DEPTH)
                r.status = ST_FULL;
            else begin
                q_key.insert(q_key.size(), b.node_key);
                q_wgt.insert(q_wgt.size(), b.path_weight);
                q_len.insert(q_len.size(), b.edge_length);
                q_prv.insert(q_prv.size(), b.prev_node);
                q_edg.insert(q_edg.size(), b.via_edge);
                r.status = ST_INSERTED;
            end
        end
        else if (q_key.size() == 0)
            r.status = ST_EMPTY;
        else begin
            best = 0;
            for (int i = 1; i < q_key.size(); i++)
                if (q_wgt[i] < q_wgt[best])
                    best = i;
            r.status     = ST_POPPED;
            r.out_node   = q_key[best];
            r.out_weight = q_wgt[best];
            r.out_length = q_len[best];
            r.out_prev   = q_prv[best];
            r.out_edge   = q_edg[best];
            q_key.delete(best);
            q_wgt.delete(best);
            q_len.delete(best);
            q_prv.delete(best);
            q_edg.delete(best);
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and run limit
    initial
    begin
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc > CYC_LIMIT)
            begin
                $display("** indexed_min_priority_queue: FAILED **");
                $finish;
            end
        end
    end

    // Send one beat and wait for it to be taken; valid drops only for a gap
    task automatic send_beat(input req_beat_t b, input bit gaps);
        int        g;
        rsp_beat_t e;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.payload <= b;
        do
            @(posedge clk);
        while (!req.ready);
        e = queue_predict(b);
        expected_rsp.insert(expected_rsp.size(), e);
        @(negedge clk);
    endtask

    task automatic push(input logic [15:0] k, input logic [31:0] w, input bit gaps = 0);
        req_beat_t b;
        b.req_type    = REQ_PUSH;
        b.node_key    = k;
        b.path_weight = w;
        b.edge_length = $urandom();
        b.prev_node   = 16'($urandom());
        b.via_edge    = 16'($urandom());
        send_beat(b, gaps);
    endtask

    task automatic pop(input bit gaps = 0);
        req_beat_t b;
        b          = '0;
        b.req_type = REQ_POP;
        b.node_key = 16'($urandom());
        send_beat(b, gaps);
    endtask

    // Receiver ready: random stalls, or a long hold-off when asked
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                rsp.ready <= 1'b0;
            else if (stall_en && $urandom_range(0, 3) == 0)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    initial
    begin
        rsp_beat_t got;
        rsp_beat_t exp_b;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                got = rsp.payload;
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected result beat, status %0d", got.status);
                    fail_count++;
                end
                else
                begin
                    exp_b = expected_rsp.pop_front();
                    if (got.status !== exp_b.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_b.status, got.status);
                        fail_count++;
                    end
                    if (got.out_node !== exp_b.out_node)
                    begin
                        $error("out_node: expected %h, got %h", exp_b.out_node, got.out_node);
                        fail_count++;
                    end
                    if (got.out_weight !== exp_b.out_weight)
                    begin
                        $error("out_weight: expected %h, got %h",
                               exp_b.out_weight, got.out_weight);
                        fail_count++;
                    end
                    if (got.out_length !== exp_b.out_length)
                    begin
                        $error("out_length: expected %h, got %h",
                               exp_b.out_length, got.out_length);
                        fail_count++;
                    end
                    if (got.out_prev !== exp_b.out_prev)
                    begin
                        $error("out_prev: expected %h, got %h", exp_b.out_prev, got.out_prev);
                        fail_count++;
                    end
                    if (got.out_edge !== exp_b.out_edge)
                    begin
                        $error("out_edge: expected %h, got %h", exp_b.out_edge, got.out_edge);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Extremes, every status, update, keep, empty pop and full queue
    task automatic test_directed();
        pop();
        push(16'h0000, 32'hFFFF_FFFF);
        push(16'hFFFF, 32'h0000_0000);
        push(16'h0000, 32'hFFFF_FFFF);
        push(16'h0000, 32'h0001_0000);
        push(16'h1234, 32'h0001_0000);
        pop();
        pop();
        pop();
        pop();
        // fill to the brim, then push new and present keys
        for (int i = 0; i < DEPTH; i++)
            push(16'(i + 100), 32'(DEPTH - i));
        push(16'h7777, 32'd1);
        push(16'd100, 32'd0);
        push(16'd101, 32'hFFFF_FFFF);
        for (int i = 0; i <= DEPTH; i++)
            pop();
    endtask

    // Push a dozen beats while the receiver holds off so the input backs up
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                push(16'($urandom_range(0, 20)), $urandom_range(0, 50));
        join
        for (int i = 0; i < 13; i++)
            pop(1);
    endtask

    // Search-like mix: small key set, decrease-keys and pops, then pops until empty
    task automatic test_random();
        req_beat_t b;
        int        n;
        n = 0;
        while (n < 260)
        begin
            b.node_key    = 16'($urandom());
            b.path_weight = $urandom();
            b.edge_length = $urandom();
            b.prev_node   = 16'($urandom());
            b.via_edge    = 16'($urandom());
            if ($urandom_range(0, 9) < 3)
                b.req_type = REQ_POP;
            else
            begin
                b.req_type = REQ_PUSH;
                if ($urandom_range(0, 9) != 0)
                    b.node_key = 16'($urandom_range(0, 90));
                if ($urandom_range(0, 3) == 0)
                    b.path_weight = $urandom_range(0, 15);
            end
            send_beat(b, 1);
            n++;
        end
        while (q_key.size() > 0)
            pop(1);
    endtask

    initial
    begin
        fail_count    = 0;
        hold_off      = 1'b0;
        stall_en      = 1'b0;
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.payload   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        stall_en = 1'b1;
        test_backpressure();
        test_random();
        // drop the last beat
        req.valid <= 1'b0;
        while (expected_rsp.size() > 0)
            @(posedge clk);
        repeat (2 * DEPTH + 10) @(posedge clk);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("** indexed_min_priority_queue: PASSED **");
        else
            $display("** indexed_min_priority_queue: FAILED **");
        $finish;
    end

endmodule
